### rtl/phst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package phst_pkg;

	// histogram geometry
	localparam int BIN_COUNT   = 256;
	localparam int COUNT_WIDTH = 22;
	localparam int BIN_W       = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

	// item field widths
	localparam int FUNC_W   = 2;
	localparam int PIX_W    = 8;
	localparam int OUT_W    = 22;
	localparam int LANES    = 3;

	// register port
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THREE_CHANNEL_MODE
	} reg_idx_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_ACCUM,
		FN_READ,
		FN_CLEAR
	} func_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// control from the sequencer to one bin lane
	typedef struct packed {
		logic             rd_en;
		logic             in_range;
		logic [BIN_W-1:0] addr;
		logic             inc_en;
		logic             clr;
	} lane_ctrl_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

`default_nettype wire

### rtl/phst_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface phst_in_if;
	import phst_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [PIX_W-1:0]  chan0_value;
	logic [PIX_W-1:0]  chan1_value;
	logic [PIX_W-1:0]  chan2_value;
	logic [PIX_W-1:0]  bin_index;

	modport source (
		output valid, func, chan0_value, chan1_value, chan2_value, bin_index,
		input  ready
	);

	modport sink (
		input  valid, func, chan0_value, chan1_value, chan2_value, bin_index,
		output ready
	);

endinterface

`default_nettype wire

### rtl/phst_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface phst_out_if;
	import phst_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] count0;
	logic [OUT_W-1:0] count1;
	logic [OUT_W-1:0] count2;

	modport source (
		output valid, count0, count1, count2,
		input  ready
	);

	modport sink (
		input  valid, count0, count1, count2,
		output ready
	);

endinterface

`default_nettype wire

### rtl/per_channel_pixel_histogram.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-channel 256-bin pixel histogram. Each channel has its own bin lane
// (a 256 x 22-bit memory with a written flag per bin), and all three lanes
// work on one item side by side. For an accumulate or read item the bin is
// read from the lane memory at the accept edge and, in the update state, the
// saturated count is written back (or the three counts are loaded into the
// output register); this read-modify-write of one memory port blocks a new
// item until the update is done. A clear item and an unused func code, which
// is dropped, need no update state. A read item waits in the update state
// while the previous result is still held. Reset and clear empty every bin at
// once through the written flags, so no clearing pass follows reset.
// three_channel_mode at byte address 0 (reset 1) selects gray counting into
// channel zero only (0) or counting of all three channels (1).
module per_channel_pixel_histogram (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire [phst_pkg::PADDR_W-1:0]     paddr,
	input  wire [phst_pkg::PDATA_W-1:0]     pwdata,
	output logic [phst_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	phst_in_if.sink                         in_item,
	phst_out_if.source                      out_item
);
	import phst_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [FUNC_W-1:0] func_q;
	logic              mode_q;
	logic              accept;
	logic              load;
	logic              can_load;
	logic              reg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [PIX_W-1:0]  lane_val [LANES];
	lane_ctrl_t        ctrl [LANES];
	count_t            count [LANES];

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (reg_wr && reg_idx == REG_THREE_CHANNEL_MODE) begin
			mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_THREE_CHANNEL_MODE) begin
			prdata[0] = mode_q;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			func_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				func_q <= in_item.func;
			end
		end
	end

	assign accept = in_item.valid && in_item.ready;

	// next state, handshake and result load
	always_comb begin
		state_d       = state_q;
		in_item.ready = 1'b0;
		load          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_item.ready = 1'b1;
				if (in_item.valid &&
				    (in_item.func == FN_ACCUM || in_item.func == FN_READ)) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (func_q == FN_READ) begin
					if (can_load) begin
						load    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// per-lane bin address and control
	always_comb begin
		lane_val[0] = in_item.chan0_value;
		lane_val[1] = in_item.chan1_value;
		lane_val[2] = in_item.chan2_value;
		for (int i = 0; i < LANES; i++) begin
			logic [PIX_W-1:0] sel;
			sel = (in_item.func == FN_READ) ? in_item.bin_index : lane_val[i];
			ctrl[i].rd_en    = accept &&
			                   (in_item.func == FN_ACCUM || in_item.func == FN_READ);
			ctrl[i].in_range = (32'(sel) < BIN_COUNT);
			ctrl[i].addr     = sel[BIN_W-1:0];
			ctrl[i].inc_en   = (state_q == ST_UPDATE) && (func_q == FN_ACCUM) &&
			                   ((i == 0) || mode_q);
			ctrl[i].clr      = accept && (in_item.func == FN_CLEAR);
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		phst_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl[g]),
			.count  (count[g])
		);
	end

	phst_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.count0   (count[0]),
		.count1   (count[1]),
		.count2   (count[2]),
		.can_load (can_load),
		.out_item (out_item)
	);

	a_work_enters_update: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_item.func == FN_ACCUM || in_item.func == FN_READ))
		|=> state_q == ST_UPDATE)
		else $error("accumulate or read item did not enter update");

	a_accum_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && func_q == FN_ACCUM) |=> state_q == ST_IDLE)
		else $error("accumulate item held longer than one update cycle");

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_item.valid)
		else $error("read item result not presented");

	a_load_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> state_q == ST_UPDATE && func_q == FN_READ)
		else $error("result loaded outside a read item");

endmodule

`default_nettype wire

### rtl/phst_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module phst_lane (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire phst_pkg::lane_ctrl_t ctrl,
	output phst_pkg::count_t    count
);
	import phst_pkg::*;

	count_t           mem [BIN_COUNT];
	count_t           rd_q;
	logic [BIN_W-1:0] addr_q;
	logic             hit_q;
	logic             range_q;
	logic [BIN_COUNT-1:0] valid_q;
	logic             bump;

	// bin memory: registered read at item accept, write back in update
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= mem[ctrl.addr];
		end
		if (bump) begin
			mem[addr_q] <= count + 1'b1;
		end
	end

	// lookup address and hit flag for the bin under work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			hit_q   <= 1'b0;
			range_q <= 1'b0;
		end else if (ctrl.rd_en) begin
			addr_q  <= ctrl.addr;
			range_q <= ctrl.in_range;
			hit_q   <= ctrl.in_range & valid_q[ctrl.addr];
		end
	end

	// per-bin written flags; an unwritten bin reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.clr) begin
			valid_q <= '0;
		end else if (ctrl.inc_en && range_q) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	// saturating increment
	always_comb begin
		count = hit_q ? rd_q : '0;
		bump  = ctrl.inc_en && range_q && (count != {COUNT_WIDTH{1'b1}});
	end

	a_clr_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clr |=> valid_q == '0)
		else $error("lane bins not cleared");

	a_inc_not_clr: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.inc_en |-> !ctrl.clr && !ctrl.rd_en)
		else $error("lane update overlaps lookup or clear");

	a_bump_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.inc_en && range_q) |=> valid_q[$past(addr_q)])
		else $error("updated bin not marked written");

endmodule

`default_nettype wire

### rtl/phst_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module phst_merge (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              load,
	input  wire phst_pkg::count_t count0,
	input  wire phst_pkg::count_t count1,
	input  wire phst_pkg::count_t count2,
	output logic             can_load,
	phst_out_if.source       out_item
);
	import phst_pkg::*;

	logic             valid_q;
	logic [OUT_W-1:0] c0_q;
	logic [OUT_W-1:0] c1_q;
	logic [OUT_W-1:0] c2_q;

	assign can_load = !valid_q || out_item.ready;

	// result holding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_item.ready) begin
			valid_q <= 1'b0;
		end
	end

	// gather the three lane counts into one result
	always_ff @(posedge clk) begin
		if (load) begin
			c0_q <= OUT_W'(count0);
			c1_q <= OUT_W'(count1);
			c2_q <= OUT_W'(count2);
		end
	end

	assign out_item.valid  = valid_q;
	assign out_item.count0 = c0_q;
	assign out_item.count1 = c1_q;
	assign out_item.count2 = c2_q;

endmodule

`default_nettype wire

### sim/phst_hist_checker.sv
`timescale 1ns / 1ps

// watches the pixel and count channels and the register port, keeps its own
// copy of the three bin stores and compares every count item with the oldest
// predicted one
module phst_hist_checker
	import phst_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire                  pready,
	input  wire [PADDR_W-1:0]    paddr,
	input  wire [PDATA_W-1:0]    pwdata,
	input  wire                  in_valid,
	input  wire                  in_ready,
	input  wire [FUNC_W-1:0]     func,
	input  wire [PIX_W-1:0]      chan0_value,
	input  wire [PIX_W-1:0]      chan1_value,
	input  wire [PIX_W-1:0]      chan2_value,
	input  wire [PIX_W-1:0]      bin_index,
	input  wire                  out_valid,
	input  wire                  out_ready,
	input  wire [OUT_W-1:0]      count0,
	input  wire [OUT_W-1:0]      count1,
	input  wire [OUT_W-1:0]      count2,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic [OUT_W-1:0] c0;
		logic [OUT_W-1:0] c1;
		logic [OUT_W-1:0] c2;
	} bin_counts_t;

	count_t      chan_bins [LANES][BIN_COUNT];
	bin_counts_t bin_reads [$];
	logic        color_mode;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// empty every bin of all three stores
	task automatic clear_bins();
		for (int l = 0; l < LANES; l++)
			for (int b = 0; b < BIN_COUNT; b++)
				chan_bins[l][b] = '0;
	endtask

	// one more pixel in a bin, holding at the top of the count width
	task automatic bump_bin(input int lane, input logic [PIX_W-1:0] value);
		if (int'(value) < BIN_COUNT && chan_bins[lane][value] != '1)
			chan_bins[lane][value] = chan_bins[lane][value] + 1'b1;
	endtask

	// state update and predicted count item for one accepted pixel item
	task automatic apply_pixel_item();
		bin_counts_t counts;
		case (func_t'(func))
			FN_ACCUM: begin
				bump_bin(0, chan0_value);
				if (color_mode) begin
					bump_bin(1, chan1_value);
					bump_bin(2, chan2_value);
				end
			end
			FN_READ: begin
				counts = '0;
				if (int'(bin_index) < BIN_COUNT) begin
					counts.c0 = chan_bins[0][bin_index][OUT_W-1:0];
					counts.c1 = chan_bins[1][bin_index][OUT_W-1:0];
					counts.c2 = chan_bins[2][bin_index][OUT_W-1:0];
				end
				bin_reads.push_back(counts);
			end
			FN_CLEAR: clear_bins();
			default: ;
		endcase
	endtask

	// compare one count item with the oldest prediction
	task automatic check_counts();
		bin_counts_t want;
		if (bin_reads.size() == 0) begin
			$error("unexpected count item: count0 %0d count1 %0d count2 %0d",
				count0, count1, count2);
			fail_count++;
		end else begin
			want = bin_reads.pop_front();
			if (count0 !== want.c0) begin
				$error("count0 mismatch: expected %0d, actual %0d", want.c0, count0);
				fail_count++;
			end
			if (count1 !== want.c1) begin
				$error("count1 mismatch: expected %0d, actual %0d", want.c1, count1);
				fail_count++;
			end
			if (count2 !== want.c2) begin
				$error("count2 mismatch: expected %0d, actual %0d", want.c2, count2);
				fail_count++;
			end
		end
	endtask

	// results leave before the item accepted at the same edge is applied
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode = 1'b1;
			clear_bins();
			bin_reads.delete();
		end else begin
			if (psel && penable && pwrite && pready
					&& paddr[PADDR_W-1:2] == REG_THREE_CHANNEL_MODE)
				color_mode = pwdata[0];
			if (out_valid && out_ready)
				check_counts();
			if (in_valid && in_ready)
				apply_pixel_item();
		end
		pending = bin_reads.size();
	end

endmodule

### sim/tb_per_channel_pixel_histogram.sv
`timescale 1ns / 1ps

module tb_per_channel_pixel_histogram;
	import phst_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 200;
	localparam logic [FUNC_W-1:0]    FN_UNUSED    = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd1;
	localparam logic [PADDR_W-1:0]   MODE_ADDR    = {REG_THREE_CHANNEL_MODE, 2'b00};
	localparam logic [PADDR_W-1:0]   UNMAPPED_ADDR = {REG_UNMAPPED, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int fail_count;
	int pending;
	int src_idle_pct;
	int rcv_stall_pct;
	int hold_seq;
	int cycles;

	phst_in_if  pix_in ();
	phst_out_if hist_out ();

	per_channel_pixel_histogram uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_item  (pix_in),
		.out_item (hist_out)
	);

	phst_hist_checker u_hist_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.in_valid    (pix_in.valid),
		.in_ready    (pix_in.ready),
		.func        (pix_in.func),
		.chan0_value (pix_in.chan0_value),
		.chan1_value (pix_in.chan1_value),
		.chan2_value (pix_in.chan2_value),
		.bin_index   (pix_in.bin_index),
		.out_valid   (hist_out.valid),
		.out_ready   (hist_out.ready),
		.count0      (hist_out.count0),
		.count1      (hist_out.count1),
		.count2      (hist_out.count2),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// count receiver: random stalls plus an occasional long hold-off
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		hist_out.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				hist_out.ready <= 1'b0;
			end else begin
				hist_out.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
			end
		end
	end

	// register write: setup cycle then access cycle
	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// offer one pixel item; valid stays high on return so the next item can follow
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [PIX_W-1:0] v0,
			input logic [PIX_W-1:0] v1, input logic [PIX_W-1:0] v2,
			input logic [PIX_W-1:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in.valid       <= 1'b1;
		pix_in.func        <= f;
		pix_in.chan0_value <= v0;
		pix_in.chan1_value <= v1;
		pix_in.chan2_value <= v2;
		pix_in.bin_index   <= b;
		do @(posedge clk); while (!pix_in.ready);
		@(negedge clk);
	endtask

	// wait for every count item, then let the last bin write land
	task automatic drain();
		pix_in.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// half the values fall in a few hot bins so counts build up
	function automatic logic [PIX_W-1:0] pixel_value();
		if ($urandom_range(0, 1) == 0)
			return PIX_W'($urandom_range(0, 3));
		return PIX_W'($urandom_range(0, 255));
	endfunction

	task automatic send_random();
		int pick;
		logic [FUNC_W-1:0] f;
		pick = $urandom_range(0, 99);
		if (pick < 62)
			f = FN_ACCUM;
		else if (pick < 94)
			f = FN_READ;
		else if (pick < 95)
			f = FN_CLEAR;
		else
			f = FN_UNUSED;
		send_item(f, pixel_value(), pixel_value(), pixel_value(), pixel_value());
	endtask

	task automatic random_phase(input int idle_pct, input int stall_pct,
			input logic [PDATA_W-1:0] mode_word, input bit hold);
		reg_write(MODE_ADDR, mode_word);
		src_idle_pct  = idle_pct;
		rcv_stall_pct = stall_pct;
		if (hold) begin
			@(posedge clk);
			hold_seq++;
			@(negedge clk);
		end
		repeat (PHASE_ITEMS) send_random();
		drain();
	endtask

	// stimulus and verdict
	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		hold_seq = 0;
		src_idle_pct  = 0;
		rcv_stall_pct = 0;
		pix_in.valid       = 1'b0;
		pix_in.func        = FN_ACCUM;
		pix_in.chan0_value = '0;
		pix_in.chan1_value = '0;
		pix_in.chan2_value = '0;
		pix_in.bin_index   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all three channels at the reset mode, edge values, clear
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd0);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd255);
		send_item(FN_ACCUM,  8'd0,   8'd255, 8'd128, 8'd0);
		send_item(FN_ACCUM,  8'd255, 8'd255, 8'd0,   8'd0);
		send_item(FN_ACCUM,  8'hAA,  8'h55,  8'hFF,  8'h00);
		send_item(FN_UNUSED, 8'hFF,  8'hFF,  8'hFF,  8'hFF);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd0);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd255);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd128);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'hAA);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'h55);
		send_item(FN_CLEAR,  8'hFF,  8'hFF,  8'hFF,  8'hFF);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd255);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd0);
		drain();

		// gray mode, only bit 0 of the word counts
		reg_write(MODE_ADDR, 32'hFFFF_FFFE);
		send_item(FN_ACCUM,  8'd17,  8'd200, 8'd201, 8'd0);
		send_item(FN_ACCUM,  8'd17,  8'd17,  8'd17,  8'd0);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd17);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd200);
		drain();

		// a write to an unmapped register leaves gray mode in place
		reg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
		send_item(FN_ACCUM,  8'd200, 8'd17,  8'd17,  8'd0);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd200);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd17);
		drain();

		// back to three channels on top of the gray counts
		reg_write(MODE_ADDR, 32'h0000_0001);
		send_item(FN_ACCUM,  8'd17,  8'd17,  8'd17,  8'd0);
		send_item(FN_READ,   8'd0,   8'd0,   8'd0,   8'd17);
		drain();

		// random traffic under each idling pattern
		random_phase(0,  0,  32'h0000_0001, 1'b1);
		random_phase(83, 0,  32'h0000_0000, 1'b0);
		random_phase(0,  83, 32'h0000_0001, 1'b0);
		random_phase(22, 22, 32'h0000_0000, 1'b0);
		random_phase(22, 22, 32'hFFFF_FFFF, 1'b0);

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
